### rtl/hex_escape_decoder_assert.svh
// assertion macros used by the decoder top level to check itself
`ifndef HEX_ESCAPE_DECODER_ASSERT_SVH
`define HEX_ESCAPE_DECODER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define HEXD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define HEXD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/hexd_pkg.sv
package hexd_pkg;

    localparam logic [7:0] BACKSLASH = 8'h5C;
    localparam logic [7:0] LETTER_X  = 8'h78;
    localparam logic [7:0] RADIX     = 8'd16;

    // parser position within an escape
    typedef enum logic [1:0] {
        PH_TEXT,
        PH_ESC,
        PH_HEX0,
        PH_HEX1
    } phase_t;

    // one result, or a literal 'x' followed by the stored byte
    typedef enum logic {
        ENT_ONE,
        ENT_X_PAIR
    } entry_kind_t;

    typedef struct packed {
        entry_kind_t kind;
        logic [7:0]  ch;
        logic        last;
    } entry_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_digit_t;

    function automatic hex_digit_t hex_digit(input logic [7:0] c);
        hex_digit_t d;
        d.ok  = 1'b0;
        d.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.ok  = 1'b1;
            d.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d.ok  = 1'b1;
            d.val = 4'(c - 8'h61 + 8'd10);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d.ok  = 1'b1;
            d.val = 4'(c - 8'h41 + 8'd10);
        end
        return d;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // strtol-style base-16 value of two characters, modulo 256
    function automatic logic [7:0] hex_pair_value(input logic [7:0] a, input logic [7:0] b);
        hex_digit_t da;
        hex_digit_t db;
        logic [7:0] bval;
        logic [7:0] res;
        da   = hex_digit(a);
        db   = hex_digit(b);
        bval = db.ok ? {4'd0, db.val} : 8'd0;
        if (is_space(a) || a == 8'h2B) begin
            res = bval;
        end else if (a == 8'h2D) begin
            res = 8'(8'd0 - bval);
        end else if (da.ok) begin
            res = db.ok ? 8'({4'd0, da.val} * RADIX + {4'd0, db.val}) : {4'd0, da.val};
        end else begin
            res = 8'd0;
        end
        return res;
    endfunction

endpackage

### rtl/hexd_front.sv
module hexd_front import hexd_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] in_char
    input  logic          s_tlast,
    input  queue_status_t q_status,
    output logic          push,
    output entry_t        push_entry
);

    phase_t     phase_reg, phase_next;
    logic [7:0] first_hex_reg, first_hex_next;
    logic       accept;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_TEXT;
            first_hex_reg <= 8'd0;
        end else begin
            phase_reg     <= phase_next;
            first_hex_reg <= first_hex_next;
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        first_hex_next  = first_hex_reg;
        push            = 1'b0;
        push_entry.kind = ENT_ONE;
        push_entry.ch   = s_tdata;
        push_entry.last = s_tlast;
        if (accept) begin
            case (phase_reg)
                PH_TEXT: begin
                    if (s_tdata == BACKSLASH && !s_tlast) begin
                        phase_next = PH_ESC;
                    end else begin
                        push = 1'b1;
                    end
                end
                PH_ESC: begin
                    if (s_tdata == LETTER_X && !s_tlast) begin
                        phase_next = PH_HEX0;
                    end else begin
                        push       = 1'b1;
                        phase_next = PH_TEXT;
                    end
                end
                PH_HEX0: begin
                    if (s_tlast) begin
                        push            = 1'b1;
                        push_entry.kind = ENT_X_PAIR;
                        phase_next      = PH_TEXT;
                    end else begin
                        first_hex_next = s_tdata;
                        phase_next     = PH_HEX1;
                    end
                end
                PH_HEX1: begin
                    push          = 1'b1;
                    push_entry.ch = hex_pair_value(first_hex_reg, s_tdata);
                    phase_next    = PH_TEXT;
                end
                default: begin
                    phase_next = PH_TEXT;
                end
            endcase
            if (s_tlast) begin
                phase_next = PH_TEXT;
            end
        end
    end

endmodule

### rtl/hexd_queue.sv
module hexd_queue import hexd_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  entry_t        push_entry,
    input  logic          pop,
    output entry_t        head_entry,
    output queue_status_t q_status
);

    entry_t     slot_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, rd_ptr_reg;

    assign head_entry     = slot_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == 2'd2);
    assign q_status.empty = (count_reg == 2'd0);

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### rtl/hexd_back.sv
module hexd_back import hexd_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  entry_t        head_entry,
    input  queue_status_t q_status,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,   // [7:0] out_char
    output logic          m_tlast
);

    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;
    logic       m_tlast_reg, m_tlast_next;
    logic       x_sent_reg, x_sent_next;
    logic       load;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // output register takes a new item from a non-empty queue whenever it is empty or being drained
    assign load = !q_status.empty && (!m_tvalid_reg || m_tready);

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        x_sent_next   = x_sent_reg;
        pop           = 1'b0;
        if (load) begin
            m_tvalid_next = 1'b1;
            if (head_entry.kind == ENT_X_PAIR && !x_sent_reg) begin
                m_tdata_next = LETTER_X;
                m_tlast_next = 1'b0;
                x_sent_next  = 1'b1;
            end else begin
                m_tdata_next = head_entry.ch;
                m_tlast_next = head_entry.last;
                x_sent_next  = 1'b0;
                pop          = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            x_sent_reg   <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            x_sent_reg   <= x_sent_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

endmodule

### rtl/hex_escape_decoder.sv
// Backslash hex escape decoder: takes an escaped string one byte per item on the
// s_ channel (tlast on its final byte) and gives the unescaped bytes on the m_ channel.
// A backslash, an 'x' and two characters become one byte, the two characters read as
// base-16 text with strtol rules (leading whitespace, one sign, partial digits, 0 with
// no digits, negative values modulo 256). A backslash before any other character gives
// that character; a string that ends after a backslash and an 'x' gives the 'x' and
// any held character literally. The last result of each string carries tlast.
// Rate: one input item per cycle while m_tready is high and the queue is not full; each
// result is written into the queue and from there loaded into the output register. A string
// whose final byte lands right after backslash-x emits two items, both through the
// output register; the two-entry queue between the parser and the output stage holds
// the extra entry, and with m_tready high an item sent right after such an end waits in
// the queue. A long output stall fills the queue and holds s_tready low until it drains.
module hex_escape_decoder import hexd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_char
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast    // out_last
);

`include "hex_escape_decoder_assert.svh"

    // parser to queue
    logic          q_push;
    entry_t        q_push_entry;
    // queue to output stage
    logic          q_pop;
    entry_t        q_head;
    queue_status_t q_status;

    // front: escape parser, turns the input items into queue entries
    hexd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_status   (q_status),
        .push       (q_push),
        .push_entry (q_push_entry)
    );

    // two-entry queue decoupling parser and output stage
    hexd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .head_entry (q_head),
        .q_status   (q_status)
    );

    // back: expands entries into output items behind an output register
    hexd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_entry (q_head),
        .q_status   (q_status),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // no write into a full queue
    `HEXD_ASSERT_NOW(a_no_push_full, aclk, aresetn, q_push, !q_status.full, "push into full queue")
    // no read from an empty queue
    `HEXD_ASSERT_NOW(a_no_pop_empty, aclk, aresetn, q_pop, !q_status.empty, "pop from empty queue")
    // one entry held, one more written, none drained: queue fills
    `HEXD_ASSERT_NEXT(a_fill, aclk, aresetn, q_push && !q_pop && !q_status.empty, q_status.full, "queue count lost")

endmodule

### verif/hex_escape_decoder_tb.sv
module hex_escape_decoder_tb;
    import hexd_pkg::*;

    // run length and safety margins
    localparam int RANDOM_ITEMS = 1950;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    // characters the hex value rules care about
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    // one unescaped byte as it should leave the block
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } out_byte_t;

    // tracks the escape parser and holds the bytes it should give, oldest first
    class unescape_board;
        out_byte_t  expected_bytes[$];
        phase_t     phase;
        logic [7:0] held_char;
        int         mismatch_count;

        function new();
            phase          = PH_TEXT;
            held_char      = 8'h00;
            mismatch_count = 0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // value of one hex digit, -1 for anything else
        function int digit_of(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c - "0");
            if (c >= "a" && c <= "f") return int'(c - "a") + 10;
            if (c >= "A" && c <= "F") return int'(c - "A") + 10;
            return -1;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
        endfunction

        // strtol base 16 over two characters, kept to 8 bits
        function logic [7:0] hex_pair(logic [7:0] a, logic [7:0] b);
            int hi;
            int lo;
            int lo_or_zero;
            hi = digit_of(a);
            lo = digit_of(b);
            lo_or_zero = (lo >= 0) ? lo : 0;
            if (is_blank(a) || a == CH_PLUS) return 8'(lo_or_zero);
            if (a == CH_MINUS) return 8'(0 - lo_or_zero);
            if (hi >= 0) return (lo >= 0) ? 8'(hi * RADIX + lo) : 8'(hi);
            return 8'h00;
        endfunction

        function void expect_byte(logic [7:0] ch, logic last);
            out_byte_t item;
            item.ch   = ch;
            item.last = last;
            expected_bytes.push_back(item);
        endfunction

        function void note_escaped_byte(logic [7:0] c, logic last);
            case (phase)
                PH_TEXT: begin
                    if (c == BACKSLASH && !last) phase = PH_ESC;
                    else expect_byte(c, last);
                end
                PH_ESC: begin
                    if (c == LETTER_X && !last) begin
                        phase = PH_HEX0;
                    end else begin
                        expect_byte(c, last);
                        phase = PH_TEXT;
                    end
                end
                PH_HEX0: begin
                    if (last) begin
                        // string cut short after backslash x
                        expect_byte(LETTER_X, 1'b0);
                        expect_byte(c, 1'b1);
                    end else begin
                        held_char = c;
                        phase     = PH_HEX1;
                    end
                end
                default: begin
                    expect_byte(hex_pair(held_char, c), last);
                    phase = PH_TEXT;
                end
            endcase
            if (last) phase = PH_TEXT;
        endfunction

        task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
            mismatch_count++;
            $display("tb: mismatch on %s at %0t: got %02h, expected %02h", what, $time, got, want);
        endtask

        task check_unescaped_byte(logic [7:0] ch, logic last);
            out_byte_t want;
            if (expected_bytes.size() == 0) begin
                report_mismatch("unexpected item", ch, 8'h00);
                return;
            end
            want = expected_bytes.pop_front();
            if (ch !== want.ch) report_mismatch("out_char", ch, want.ch);
            if (last !== want.last) report_mismatch("out_last", {7'd0, last}, {7'd0, want.last});
        endtask
    endclass

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h01;   // [7:0] in_char
    logic       s_tlast  = 1'b0;    // in_last
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_char
    logic       m_tlast;            // out_last

    unescape_board board;
    logic [7:0]    text_bytes[$];   // the string being sent
    int            items_sent  = 0;
    int            burst_left  = 0;
    int            cycle_count = 0;
    int            ready_mode  = 0;
    int            ready_left  = 0;

    hex_escape_decoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // both handshakes seen with the values from before the edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) board.note_escaped_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) board.check_unescaped_byte(m_tdata, m_tlast);
        end
    end

    // receiver stalls in modes: always ready, coin flip, periodic ready, short full stall
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_left = (ready_mode == 3) ? $urandom_range(1, 12) : $urandom_range(1, 80);
        end
        ready_left = ready_left - 1;
        case (ready_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_tready <= (cycle_count % 4) == 0;
            end
            default: begin
                m_tready <= 1'b0;
            end
        endcase
    end

    // sends text_bytes as one string, tlast on its final byte, in bursts with gaps
    task automatic send_bytes();
        int gap;
        for (int i = 0; i < text_bytes.size(); i++) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(0, 12);
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 30);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            s_tvalid <= 1'b1;
            s_tdata  <= text_bytes[i];
            s_tlast  <= (i == text_bytes.size() - 1);
            do @(posedge aclk); while (!s_tready);
            burst_left--;
            items_sent++;
        end
    endtask

    task automatic send_text(string s);
        text_bytes.delete();
        for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
        send_bytes();
    endtask

    // hold the sender off until every expected byte has come out
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
    endtask

    // mostly hex digits, sometimes whitespace, a sign or any byte
    function automatic logic [7:0] pick_hex_char();
        string digits;
        int    pick;
        digits = "0123456789abcdefABCDEF";
        pick   = $urandom_range(0, 29);
        if (pick < 22) return digits[pick];
        if (pick < 24) return ($urandom_range(0, 1) == 1) ? CH_SPACE : 8'($urandom_range(9, 13));
        if (pick < 25) return CH_PLUS;
        if (pick < 26) return CH_MINUS;
        return 8'($urandom_range(1, 255));
    endfunction

    // a string of plain bytes and escapes, some of them cut short at the end
    task automatic build_random_string();
        int segments;
        text_bytes.delete();
        segments = $urandom_range(1, 6);
        for (int i = 0; i < segments; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 9: begin
                    text_bytes.push_back(8'($urandom_range(1, 255)));
                end
                3, 4, 5: begin
                    text_bytes.push_back(BACKSLASH);
                    text_bytes.push_back(LETTER_X);
                    text_bytes.push_back(pick_hex_char());
                    text_bytes.push_back(pick_hex_char());
                end
                6: begin
                    // escaped ordinary character
                    text_bytes.push_back(BACKSLASH);
                    text_bytes.push_back(8'($urandom_range(1, 255)));
                end
                7: begin
                    text_bytes.push_back(BACKSLASH);
                    text_bytes.push_back(LETTER_X);
                    text_bytes.push_back(8'($urandom_range(1, 255)));
                    text_bytes.push_back(8'($urandom_range(1, 255)));
                end
                default: begin
                    text_bytes.push_back(($urandom_range(0, 1) == 1) ? BACKSLASH : LETTER_X);
                end
            endcase
        end
        if ($urandom_range(0, 4) == 0) begin
            // early end inside an escape
            text_bytes.push_back(BACKSLASH);
            if ($urandom_range(0, 2) != 0) text_bytes.push_back(LETTER_X);
            if ($urandom_range(0, 1) == 1) text_bytes.push_back(pick_hex_char());
        end
    endtask

    initial begin
        board = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // lowest nonzero and highest byte as plain text
        text_bytes = '{8'h01, 8'hFF};
        send_bytes();
        send_text("\\x4a");     // full hex pair
        send_text("\\x-1");     // negative wraps to ff
        send_text("\\x 9");     // leading whitespace
        send_text("\\x+G");     // sign with no digits gives zero
        send_text("\\x7z");     // one digit then a non-digit
        send_text("\\q");       // escaped ordinary character
        send_text("\\");        // lone backslash at the end
        send_text("\\x");       // end right on the x
        send_text("\\xA");      // end after one held character
        wait_for_drain();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            build_random_string();
            send_bytes();
            if ($urandom_range(0, 49) == 0) wait_for_drain();
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.pending() == 0 && board.mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // stuck handshake guard
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

endmodule
